[hw/rtl/fixed_block_pool_allocator_unit_macros.svh]
// assertion helpers used by the allocator rtl
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FBPA_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FBPA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fbpa_pkg.sv]
package fbpa_pkg;

	localparam int unsigned MAX_BLOCKS_DEF = 256;

	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned BSIZE_W   = 16;
	localparam int unsigned CNT_W     = 9;
	localparam int unsigned IDX_OUT_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned DIV_STEPS = ADDR_W;

	// operations
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BSIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS = 2'd2;

	localparam logic [ADDR_W-1:0]  BASE_RST   = 32'd0;
	localparam logic [BSIZE_W-1:0] BSIZE_RST  = 16'd16;
	localparam logic [CNT_W-1:0]   BLOCKS_RST = 9'd256;

	typedef struct packed {
		logic                start;
		logic [ADDR_W-1:0]   dividend;
		logic [BSIZE_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [ADDR_W-1:0]   quotient;
	} div_rsp_t;

	// managed block count, capped at the pool capacity
	function automatic logic [CNT_W-1:0] pool_count(input logic [CNT_W-1:0] n,
			input int unsigned maxb);
		logic [CNT_W-1:0] r;
		r = (32'(n) > maxb) ? CNT_W'(maxb) : n;
		return r;
	endfunction

endpackage

[hw/rtl/fbpa_ram.sv]
module fbpa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/fbpa_div.sv]
module fbpa_div import fbpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [ADDR_W-1:0]          dvd_q;
	logic [BSIZE_W-1:0]         rem_q;
	logic [BSIZE_W-1:0]         dsr_q;
	logic [$clog2(DIV_STEPS)-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [BSIZE_W:0] rem_sh;
	logic [BSIZE_W:0] diff;
	logic             qbit;

	// restoring division, one quotient bit per cycle; a zero divisor gives all ones
	assign rem_sh = {rem_q, dvd_q[ADDR_W-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};
	assign qbit   = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(DIV_STEPS)'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ADDR_W-2:0], qbit};
			rem_q <= qbit ? diff[BSIZE_W-1:0] : rem_sh[BSIZE_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

[hw/rtl/fixed_block_pool_allocator_unit.sv]
// Fixed-size block pool allocator with a free list kept in an on-chip link
// RAM and built lazily, one block per allocate. cmd 0 allocates and returns
// base_address + index * bytes per block; cmd 1 returns the block at
// free_address. One transaction is in work at a time; the result register
// lets the next transaction be accepted while a result waits. A successful
// allocate passes the link RAM write, registered link read, multiply and add
// stages to its result, skipping the link read when it takes the last free
// block. A failed allocate goes straight to its result. A free waits for the
// bit-serial 32-step index divider. A result held by out_ready low stalls
// the sequence in its final cycle. A base, block size or block count write
// re-creates the pool at once; no clearing pass is needed.
`include "fixed_block_pool_allocator_unit_macros.svh"

module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
	parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [ADDR_W-1:0]    free_address,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [ADDR_W-1:0]    block_address,
	output logic [IDX_OUT_W-1:0] block_index,
	output logic [CNT_W-1:0]     free_count
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned LW = $clog2(MAX_BLOCKS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_AINIT  = 4'd1;
	localparam logic [3:0] S_AREAD  = 4'd2;
	localparam logic [3:0] S_ALINK  = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_ADD    = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_FINISH = 4'd7;

	logic [3:0]         state_q;

	logic [ADDR_W-1:0]  base_q;
	logic [BSIZE_W-1:0] blk_bytes_q;
	logic [CNT_W-1:0]   num_q;
	logic [CNT_W-1:0]   free_blocks_q;
	logic [CNT_W-1:0]   init_q;
	logic [IW-1:0]      head_q;
	logic               head_valid_q;

	logic [1:0]         res_status_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic [IW-1:0]      res_idx_q;
	logic [ADDR_W-1:0]  prod_s1;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [CNT_W-1:0]   out_free_q;

	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [LW-1:0]      ram_wdata;
	logic               ram_re;
	logic [LW-1:0]      ram_rdata;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic               cfg_hit;
	logic [CNT_W-1:0]   num_new;
	logic               pop_ok;
	logic               init_left;
	logic               free_ok;
	logic [ADDR_W-1:0]  prod_w;
	logic [BSIZE_W-1:0] mul_a;
	logic               out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;

	assign cfg_hit = cfg_valid && (cfg_index == REG_BASE || cfg_index == REG_BSIZE
		|| cfg_index == REG_BLOCKS);
	assign num_new = (cfg_index == REG_BLOCKS) ? pool_count(cfg_data[CNT_W-1:0], MAX_BLOCKS)
		: num_q;

	assign init_left = (init_q < num_q);
	assign pop_ok    = (free_blocks_q != '0) && head_valid_q && (32'(head_q) < 32'(num_q));
	assign free_ok   = (free_blocks_q < num_q) && (div_rsp.quotient < 32'(num_q));

	assign mul_a  = BSIZE_W'(res_idx_q);
	assign prod_w = mul_a * blk_bytes_q;

	assign div_req.start    = in_valid && in_ready && (cmd == CMD_FREE);
	assign div_req.dividend = free_address - base_q;
	assign div_req.divisor  = blk_bytes_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IW'(init_q);
		ram_wdata = LW'(init_q + CNT_W'(1));
		ram_re    = (state_q == S_AREAD);
		if (state_q == S_AINIT) begin
			// lazy link of the next untouched block to its successor
			ram_we = init_left;
		end else if (state_q == S_DIV && div_rsp.done && free_ok) begin
			ram_we    = 1'b1;
			ram_waddr = IW'(div_rsp.quotient);
			ram_wdata = head_valid_q ? LW'(head_q) : LW'(num_q);
		end
	end

	fbpa_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	fbpa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			base_q        <= BASE_RST;
			blk_bytes_q   <= BSIZE_RST;
			num_q         <= pool_count(BLOCKS_RST, MAX_BLOCKS);
			free_blocks_q <= pool_count(BLOCKS_RST, MAX_BLOCKS);
			init_q        <= '0;
			head_q        <= '0;
			head_valid_q  <= 1'b1;
			out_valid_q   <= 1'b0;
		end else if (cfg_hit) begin
			// a base, block size or block count write re-creates the pool
			if (cfg_index == REG_BASE) begin
				base_q <= cfg_data;
			end
			if (cfg_index == REG_BSIZE) begin
				blk_bytes_q <= cfg_data[BSIZE_W-1:0];
			end
			num_q         <= num_new;
			free_blocks_q <= num_new;
			init_q        <= '0;
			head_q        <= '0;
			head_valid_q  <= 1'b1;
		end else begin
			// the finish state reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (cmd == CMD_FREE) ? S_DIV : S_AINIT;
					end
				end
				S_AINIT: begin
					if (init_left) begin
						init_q <= init_q + 1'b1;
					end
					if (pop_ok) begin
						free_blocks_q <= free_blocks_q - 1'b1;
						if (free_blocks_q != CNT_W'(1)) begin
							state_q <= S_AREAD;
						end else begin
							head_valid_q <= 1'b0;
							state_q      <= S_MUL;
						end
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_AREAD: begin
					state_q <= S_ALINK;
				end
				S_ALINK: begin
					// a link past the pool marks the list as broken
					if (32'(ram_rdata) < 32'(num_q)) begin
						head_q <= IW'(ram_rdata);
					end else begin
						head_valid_q <= 1'b0;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_FINISH;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (free_ok) begin
							head_q        <= IW'(div_rsp.quotient);
							head_valid_q  <= 1'b1;
							free_blocks_q <= free_blocks_q + 1'b1;
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_AINIT: begin
				res_idx_q    <= pop_ok ? head_q : '0;
				res_addr_q   <= '0;
				res_status_q <= pop_ok ? STAT_OK : STAT_EMPTY;
			end
			S_MUL: begin
				prod_s1 <= prod_w;
			end
			S_ADD: begin
				res_addr_q <= base_q + prod_s1;
			end
			S_DIV: begin
				res_addr_q <= '0;
				if (free_blocks_q >= num_q) begin
					res_status_q <= STAT_FULL;
					res_idx_q    <= '0;
				end else if (div_rsp.quotient >= 32'(num_q)) begin
					res_status_q <= STAT_RANGE;
					res_idx_q    <= '0;
				end else begin
					res_status_q <= STAT_OK;
					res_idx_q    <= IW'(div_rsp.quotient);
				end
			end
			S_FINISH: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_addr_q   <= res_addr_q;
					out_idx_q    <= IDX_OUT_W'(res_idx_q);
					out_free_q   <= free_blocks_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign block_address = out_addr_q;
	assign block_index   = out_idx_q;
	assign free_count    = out_free_q;

	`FBPA_ASSERT_SAME(a_free_within_pool, clk, arst_n, 1'b1, free_blocks_q <= num_q,
		"free count exceeds pool size")
	`FBPA_ASSERT_NEXT(a_accept_starts_work, clk, arst_n, in_valid && in_ready && !cfg_hit,
		state_q != S_IDLE, "accepted transaction did not start")
	`FBPA_ASSERT_SAME(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == S_DIV,
		"divider finished outside the free sequence")
	`FBPA_ASSERT_SAME(a_ram_no_overlap, clk, arst_n, ram_we, !ram_re,
		"link ram read and write in the same cycle")

endmodule

[tb/fbpa_alloc_checker.sv]
module fbpa_alloc_checker import fbpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 cmd,
	input  logic [ADDR_W-1:0]    free_address,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [1:0]           status,
	input  logic [ADDR_W-1:0]    block_address,
	input  logic [IDX_OUT_W-1:0] block_index,
	input  logic [CNT_W-1:0]     free_count,
	output int unsigned          pending,
	output int unsigned          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned POOL_CAP = MAX_BLOCKS_DEF;

	typedef struct packed {
		logic [1:0]           st;
		logic [ADDR_W-1:0]    addr;
		logic [IDX_OUT_W-1:0] idx;
		logic [CNT_W-1:0]     cnt;
	} pool_result_t;

	logic [ADDR_W-1:0]    base_reg;
	logic [BSIZE_W-1:0]   bsize_reg;
	logic [CNT_W-1:0]     blocks_reg;
	logic [CNT_W-1:0]     link_mem [POOL_CAP];
	logic [IDX_OUT_W-1:0] head_idx;
	logic                 head_ok;
	logic [CNT_W-1:0]     free_cnt;
	logic [CNT_W-1:0]     init_cnt;
	pool_result_t         expected_results [$];
	int unsigned          bad_seen;

	function automatic logic [CNT_W-1:0] managed_blocks();
		return (blocks_reg > CNT_W'(POOL_CAP)) ? CNT_W'(POOL_CAP) : blocks_reg;
	endfunction

	task automatic rebuild_pool();
		head_idx = '0;
		head_ok  = 1'b1;
		free_cnt = managed_blocks();
		init_cnt = '0;
	endtask

	task automatic predict_pool_op(input logic op, input logic [ADDR_W-1:0] addr,
			output pool_result_t r);
		logic [CNT_W-1:0]  num;
		logic [CNT_W-1:0]  nxt;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] quo;
		num = managed_blocks();
		r = '0;
		r.st = STAT_OK;
		if (op == CMD_ALLOC) begin
			// lazy build: link the next untouched block to its successor
			if (init_cnt < num) begin
				link_mem[init_cnt[IDX_OUT_W-1:0]] = init_cnt + 1'b1;
				init_cnt = init_cnt + 1'b1;
			end
			if (free_cnt != 0 && head_ok && {1'b0, head_idx} < num) begin
				r.idx = head_idx;
				r.addr = base_reg + ADDR_W'(head_idx) * ADDR_W'(bsize_reg);
				free_cnt = free_cnt - 1'b1;
				if (free_cnt != 0) begin
					nxt = link_mem[head_idx];
					if (nxt < num) begin
						head_idx = nxt[IDX_OUT_W-1:0];
					end else begin
						head_ok = 1'b0;
					end
				end else begin
					head_ok = 1'b0;
				end
			end else begin
				r.st = STAT_EMPTY;
			end
		end else begin
			offset = addr - base_reg;
			// a zero divisor saturates the quotient
			quo = (bsize_reg != 0) ? offset / ADDR_W'(bsize_reg) : '1;
			if (free_cnt >= num) begin
				r.st = STAT_FULL;
			end else if (quo >= ADDR_W'(num)) begin
				r.st = STAT_RANGE;
			end else begin
				link_mem[quo[IDX_OUT_W-1:0]] = head_ok ? {1'b0, head_idx} : num;
				head_idx = quo[IDX_OUT_W-1:0];
				head_ok = 1'b1;
				free_cnt = free_cnt + 1'b1;
				r.idx = quo[IDX_OUT_W-1:0];
			end
		end
		r.cnt = free_cnt;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pool_result_t want;
		pool_result_t seen;
		if (!arst_n) begin
			base_reg = BASE_RST;
			bsize_reg = BSIZE_RST;
			blocks_reg = BLOCKS_RST;
			for (int i = 0; i < POOL_CAP; i++) link_mem[i] = '0;
			rebuild_pool();
			expected_results.delete();
			bad_seen = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {status, block_address, block_index, free_count};
				if (expected_results.size() == 0) begin
					bad_seen++;
					if (bad_seen <= 10)
						$display("%0t: unexpected result status %0d address %h index %0d free %0d",
							$time, seen.st, seen.addr, seen.idx, seen.cnt);
				end else begin
					want = expected_results.pop_front();
					if (seen.st !== want.st || seen.addr !== want.addr ||
							seen.idx !== want.idx || seen.cnt !== want.cnt) begin
						bad_seen++;
						if (bad_seen <= 10)
							$display({"%0t: mismatch, expected status %0d address %h index %0d",
								" free %0d, got status %0d address %h index %0d free %0d"},
								$time, want.st, want.addr, want.idx, want.cnt,
								seen.st, seen.addr, seen.idx, seen.cnt);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_pool_op(cmd, free_address, want);
				expected_results.push_back(want);
			end
			// any real register write re-creates the pool
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASE: begin
						base_reg = cfg_data;
						rebuild_pool();
					end
					REG_BSIZE: begin
						bsize_reg = cfg_data[BSIZE_W-1:0];
						rebuild_pool();
					end
					REG_BLOCKS: begin
						blocks_reg = cfg_data[CNT_W-1:0];
						rebuild_pool();
					end
					default: ;
				endcase
			end
			pending <= expected_results.size();
			mismatches <= bad_seen;
		end
	end

endmodule

[tb/fixed_block_pool_allocator_unit_tb.sv]
module fixed_block_pool_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fbpa_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned DRAIN_CYCLES  = 40;
	localparam int unsigned RANDOM_PHASES = 9;
	localparam int unsigned PHASE_ITEMS   = 115;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 cmd = CMD_ALLOC;
	logic [ADDR_W-1:0]    free_address = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           status;
	logic [ADDR_W-1:0]    block_address;
	logic [IDX_OUT_W-1:0] block_index;
	logic [CNT_W-1:0]     free_count;
	int unsigned          pending;
	int unsigned          mismatches;

	logic                 idle_on = 1'b1;
	int unsigned          stall_left = 0;
	int unsigned          cycles = 0;
	logic [ADDR_W-1:0]    cur_base = BASE_RST;
	logic [BSIZE_W-1:0]   cur_bsize = BSIZE_RST;
	logic [CNT_W-1:0]     cur_blocks = BLOCKS_RST;
	logic [ADDR_W-1:0]    live_blocks [$];
	logic                 sent_ops [$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	fixed_block_pool_allocator_unit u_dut (.*);

	fbpa_alloc_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 10);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// keep the granted addresses so that most frees return a live block
	always @(posedge clk) begin
		if (out_valid && out_ready && sent_ops.size() != 0) begin
			if (sent_ops.pop_front() == CMD_ALLOC && status == STAT_OK)
				live_blocks.push_back(block_address);
		end
		if (in_valid && in_ready) sent_ops.push_back(cmd);
	end

	function automatic logic [ADDR_W-1:0] block_addr(input int unsigned i);
		return cur_base + ADDR_W'(i) * ADDR_W'(cur_bsize);
	endfunction

	task automatic send(input logic op, input logic [ADDR_W-1:0] addr);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		free_address <= addr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_pool(input logic [ADDR_W-1:0] b, input logic [BSIZE_W-1:0] s,
			input logic [CNT_W-1:0] n);
		drain();
		// unused upper data bits carry noise
		write_reg(REG_BASE, b);
		write_reg(REG_BSIZE, {16'($urandom), s});
		write_reg(REG_BLOCKS, {23'($urandom), n});
		cfg_valid <= 1'b0;
		cur_base = b;
		cur_bsize = s;
		cur_blocks = n;
		live_blocks.delete();
	endtask

	initial begin
		logic [ADDR_W-1:0]  a;
		logic [ADDR_W-1:0]  b;
		logic [BSIZE_W-1:0] s;
		logic [CNT_W-1:0]   n;
		int unsigned        pick;
		int unsigned        alloc_pct;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: free into a full pool, out-of-range free
		send(CMD_FREE, block_addr(0));
		send(CMD_ALLOC, $urandom);
		send(CMD_FREE, 32'hFFFF_FFFF);
		// spare index must leave the pool alone
		drain();
		write_reg(REG_SPARE, $urandom);
		cfg_valid <= 1'b0;
		send(CMD_FREE, block_addr(0) + 15);
		send(CMD_ALLOC, $urandom);
		send(CMD_ALLOC, $urandom);

		// tiny pool: lazy link overwritten under a pushed block breaks the list
		set_pool(32'h0000_1000, 16'd4, 9'd4);
		send(CMD_ALLOC, $urandom);
		send(CMD_ALLOC, $urandom);
		send(CMD_FREE, block_addr(3));
		send(CMD_FREE, block_addr(0));
		send(CMD_ALLOC, $urandom);
		send(CMD_ALLOC, $urandom);
		send(CMD_ALLOC, $urandom);
		send(CMD_FREE, 32'h0000_0FFF);

		// top base and size with a saturated block count, address wraps
		set_pool(32'hFFFF_FFFF, 16'hFFFF, 9'd511);
		send(CMD_ALLOC, $urandom);
		send(CMD_ALLOC, $urandom);
		send(CMD_FREE, block_addr(1));
		send(CMD_FREE, block_addr(0));
		send(CMD_FREE, block_addr(0));

		// zero block size
		set_pool(32'h8000_0000, 16'd0, 9'd1);
		send(CMD_ALLOC, $urandom);
		send(CMD_ALLOC, $urandom);
		send(CMD_FREE, cur_base);
		send(CMD_FREE, $urandom);

		// empty pool
		set_pool(32'h0000_0000, 16'd1, 9'd0);
		send(CMD_ALLOC, $urandom);
		send(CMD_FREE, 32'h0000_0000);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 3))
				0: b = '0;
				1: b = '1;
				default: b = $urandom;
			endcase
			case ($urandom_range(0, 4))
				0: s = 16'd1;
				1: s = 16'hFFFF;
				2: s = 16'(1 << $urandom_range(0, 15));
				default: s = 16'($urandom_range(2, 300));
			endcase
			case ($urandom_range(0, 5))
				0: n = 9'd256;
				1: n = 9'd511;
				2: n = 9'($urandom_range(1, 511));
				default: n = 9'($urandom_range(1, 12));
			endcase
			set_pool(b, s, n);
			idle_on <= (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			alloc_pct = $urandom_range(35, 70);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < alloc_pct) begin
					send(CMD_ALLOC, $urandom);
				end else begin
					if (live_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
						pick = $urandom_range(0, live_blocks.size() - 1);
						a = live_blocks[pick];
						live_blocks.delete(pick);
						if (cur_bsize > 1) a = a + ADDR_W'($urandom_range(0, cur_bsize - 1));
					end else begin
						case ($urandom_range(0, 2))
							0: a = $urandom;
							1: a = block_addr($urandom_range(0, cur_blocks + 2));
							default: a = cur_base - 1;
						endcase
					end
					send(CMD_FREE, a);
				end
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_div.sv
hw/rtl/fixed_block_pool_allocator_unit.sv
tb/fbpa_alloc_checker.sv
tb/fixed_block_pool_allocator_unit_tb.sv
